// ----- rtl/command_timeout_supervisor_top_macros.svh -----
// Assertion macros for the command timeout supervisor.
`ifndef COMMAND_TIMEOUT_SUPERVISOR_TOP_MACROS_SVH
`define COMMAND_TIMEOUT_SUPERVISOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("supervisor check failed");

// Next-cycle implication, checked outside reset.
`define CTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("supervisor check failed");

// Condition that must hold in the cycle after reset is applied.
`define CTS_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("supervisor reset check failed");

`endif

// ----- rtl/cts_pkg.sv -----
// Types and constants for the command timeout supervisor.
`default_nettype none

package cts_pkg;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned ADC_W      = 12;
    localparam int unsigned SLOT_W     = 2;
    localparam int unsigned CUR_W      = 20;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned FEED_W     = 16;
    localparam int unsigned MASK_W     = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 48;
    localparam int unsigned M_TDATA_W  = 32;

    // Reset values of the configuration registers.
    localparam logic [TIME_W-1:0] TIMEOUT_RST   = 32'd1000;
    localparam logic [CUR_W-1:0]  BRAKE_CUR_RST = 20'd0;
    localparam logic [ADC_W-1:0]  ADC_THR_RST   = 12'd2048;  // 1.65 V at 3.3 V full scale
    localparam logic [FEED_W-1:0] MIN_FEEDS_RST = 16'd1;
    localparam logic [MASK_W-1:0] MON_MASK_RST  = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 2'd0,
        OP_REFRESH = 2'd1,
        OP_FEED    = 2'd2
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        KILL_OFF      = 3'd0,
        KILL_PIN_LOW  = 3'd1,
        KILL_PIN_HIGH = 3'd2,
        KILL_ADC_LOW  = 3'd3,
        KILL_ADC_HIGH = 3'd4
    } kill_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 3'd0,
        CFG_BRAKE_CUR = 3'd1,
        CFG_KILL_MODE = 3'd2,
        CFG_ADC_THR   = 3'd3,
        CFG_MIN_FEEDS = 3'd4,
        CFG_MON_MASK  = 3'd5
    } cfg_idx_t;

    // Result word, brake_apply in bit 0.
    typedef struct packed {
        logic [CUR_W-1:0] brake_current_out;
        logic             watchdog_feed;
        logic             kill_active;
        logic             timed_out;
        logic             ignore_input;
        logic             release_override;
        logic             brake_apply;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage : cts_pkg

`default_nettype wire

// ----- rtl/command_timeout_supervisor_top.sv -----
// Command timeout supervisor with kill switch and thread liveness watchdog.
// A word's result is registered in res_reg and shows at m_tdata in the cycle after the word is accepted.
// Throughput: one word per cycle; a word is taken whenever the output register
// is empty or being drained in the same cycle.
// Reset: synchronous active-low aresetn clears flags, feed counters, command time
// and the output valid, and loads the configuration registers with their defaults.
`default_nettype none

module command_timeout_supervisor_top #(
    parameter int unsigned NUM_THREADS = 4    // feed counter slots, 1 to 4
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    // Input stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // s_tdata: now_ms[31:0], pin_level[32], adc_sample[44:33],
    //          thread_index[46:45], zero pad[47]
    input  wire logic [cts_pkg::S_TDATA_W-1:0]      s_tdata,
    // s_tuser: operation[1:0]
    input  wire logic [cts_pkg::OP_W-1:0]           s_tuser,

    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // m_tdata: brake_apply[0], release_override[1], ignore_input[2],
    //          timed_out[3], kill_active[4], watchdog_feed[5],
    //          brake_current_out[25:6], zero pad[31:26]
    output logic [cts_pkg::M_TDATA_W-1:0]           m_tdata,

    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cts_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cts_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers. Writes are always taken.
    // ---------------------------------------------------------------
    logic [cts_pkg::TIME_W-1:0]   timeout_reg;
    logic [cts_pkg::CUR_W-1:0]    brake_cur_reg;
    logic [cts_pkg::MODE_W-1:0]   kill_mode_reg;
    logic [cts_pkg::ADC_W-1:0]    adc_thr_reg;
    logic [cts_pkg::FEED_W-1:0]   min_feeds_reg;
    logic [cts_pkg::MASK_W-1:0]   mon_mask_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= cts_pkg::TIMEOUT_RST;
            brake_cur_reg <= cts_pkg::BRAKE_CUR_RST;
            kill_mode_reg <= cts_pkg::KILL_OFF;
            adc_thr_reg   <= cts_pkg::ADC_THR_RST;
            min_feeds_reg <= cts_pkg::MIN_FEEDS_RST;
            mon_mask_reg  <= cts_pkg::MON_MASK_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cts_pkg::cfg_idx_t'(cfg_index))
                cts_pkg::CFG_TIMEOUT:   timeout_reg   <= cfg_data;
                cts_pkg::CFG_BRAKE_CUR: brake_cur_reg <= cfg_data[cts_pkg::CUR_W-1:0];
                cts_pkg::CFG_KILL_MODE: kill_mode_reg <= cfg_data[cts_pkg::MODE_W-1:0];
                cts_pkg::CFG_ADC_THR:   adc_thr_reg   <= cfg_data[cts_pkg::ADC_W-1:0];
                cts_pkg::CFG_MIN_FEEDS: min_feeds_reg <= cfg_data[cts_pkg::FEED_W-1:0];
                cts_pkg::CFG_MON_MASK:  mon_mask_reg  <= cfg_data[cts_pkg::MASK_W-1:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input word unpacking and handshake.
    // ---------------------------------------------------------------
    logic                           in_acc;
    logic [cts_pkg::TIME_W-1:0]     now_ms;
    logic                           pin_level;
    logic [cts_pkg::ADC_W-1:0]      adc_sample;
    logic [cts_pkg::SLOT_W-1:0]     thread_index;
    cts_pkg::op_t                   op;

    assign now_ms       = s_tdata[31:0];
    assign pin_level    = s_tdata[32];
    assign adc_sample   = s_tdata[44:33];
    assign thread_index = s_tdata[46:45];
    assign op           = cts_pkg::op_t'(s_tuser);

    logic                           m_valid_reg;
    cts_pkg::result_t               res_reg;
    cts_pkg::result_t               res_next;

    // Output register frees up when empty or drained this cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;

    // ---------------------------------------------------------------
    // Supervisor state.
    // ---------------------------------------------------------------
    logic [cts_pkg::TIME_W-1:0]     last_cmd_reg;
    logic                           timeout_flag_reg;
    logic                           kill_flag_reg;
    logic [cts_pkg::FEED_W-1:0]     feed_cnt_reg [NUM_THREADS];

    logic                           is_tick;
    logic                           kill;
    logic [cts_pkg::TIME_W-1:0]     elapsed;
    logic                           expired;
    logic                           brake;
    logic                           timeout_flag_next;
    logic [cts_pkg::MASK_W-1:0]     slot_alive;

    assign is_tick = (op == cts_pkg::OP_TICK);

    // Kill switch source; undefined mode codes act as disabled.
    always_comb begin
        case (cts_pkg::kill_mode_t'(kill_mode_reg))
            cts_pkg::KILL_PIN_LOW:  kill = !pin_level;
            cts_pkg::KILL_PIN_HIGH: kill = pin_level;
            cts_pkg::KILL_ADC_LOW:  kill = adc_sample < adc_thr_reg;
            cts_pkg::KILL_ADC_HIGH: kill = adc_sample > adc_thr_reg;
            default:                kill = 1'b0;
        endcase
    end

    // Wrapping elapsed time since the last command; zero timeout disables.
    assign elapsed = now_ms - last_cmd_reg;
    assign expired = (timeout_reg != '0) && (elapsed > timeout_reg);
    assign brake   = kill || expired;

    // Kill holds the timeout flag, a bare timeout sets it, neither clears it.
    always_comb begin
        if (kill) begin
            timeout_flag_next = timeout_flag_reg;
        end else begin
            timeout_flag_next = expired;
        end
    end

    // Liveness per monitored slot. The mask only spans four slots.
    for (genvar i = 0; i < cts_pkg::MASK_W; i++) begin : g_alive
        if (i < NUM_THREADS) begin : g_chk
            assign slot_alive[i] = !mon_mask_reg[i] || (feed_cnt_reg[i] >= min_feeds_reg);
        end else begin : g_none
            assign slot_alive[i] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_cmd_reg     <= '0;
            timeout_flag_reg <= 1'b0;
            kill_flag_reg    <= 1'b0;
        end else if (in_acc) begin
            if (is_tick) begin
                timeout_flag_reg <= timeout_flag_next;
                kill_flag_reg    <= kill;
            end
            if (op == cts_pkg::OP_REFRESH) begin
                last_cmd_reg <= now_ms;
            end
        end
    end

    // Feed counters: saturating, cleared by every tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                feed_cnt_reg[i] <= '0;
            end
        end else if (in_acc) begin
            for (int i = 0; i < NUM_THREADS; i++) begin
                if (is_tick) begin
                    feed_cnt_reg[i] <= '0;
                end else if (op == cts_pkg::OP_FEED && 32'(thread_index) == i
                             && feed_cnt_reg[i] != '1) begin
                    feed_cnt_reg[i] <= feed_cnt_reg[i] + 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result word.
    // ---------------------------------------------------------------
    always_comb begin
        res_next                   = '0;
        res_next.timed_out         = timeout_flag_reg;
        res_next.kill_active       = kill_flag_reg;
        if (is_tick) begin
            res_next.brake_apply       = brake;
            res_next.release_override  = brake && !timeout_flag_reg && !kill_flag_reg;
            res_next.ignore_input      = kill;
            res_next.timed_out         = timeout_flag_next;
            res_next.kill_active       = kill;
            res_next.watchdog_feed     = &slot_alive;
            res_next.brake_current_out = brake ? brake_cur_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(cts_pkg::M_TDATA_W - cts_pkg::RESULT_W)'(0), res_reg};

    // ---------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------
    logic kill_braked;
    logic out_quiet;
    logic flags_match;

    assign kill_braked = res_reg.kill_active && res_reg.brake_apply;
    assign out_quiet   = !res_reg.brake_apply && !res_reg.watchdog_feed
                         && (res_reg.brake_current_out == '0);
    assign flags_match = (res_reg.kill_active == kill_flag_reg)
                         && (res_reg.timed_out == timeout_flag_reg);

`include "command_timeout_supervisor_top_macros.svh"

    `CTS_ASSERT_SAME(a_release_needs_brake, m_valid_reg && res_reg.release_override, res_reg.brake_apply)
    `CTS_ASSERT_SAME(a_ignore_needs_kill, m_valid_reg && res_reg.ignore_input, kill_braked)
    `CTS_ASSERT_NEXT(a_nontick_quiet, in_acc && !is_tick, out_quiet)
    `CTS_ASSERT_NEXT(a_flags_follow, in_acc && is_tick, flags_match)
    `CTS_ASSERT_RST(a_reset_empty, !m_tvalid)

endmodule : command_timeout_supervisor_top

`default_nettype wire

// ----- bench/command_timeout_supervisor_top_test.sv -----
// Self-checking bench for the command timeout supervisor: directed and random words, predicted results.
module command_timeout_supervisor_top_test;
    import cts_pkg::*;

    localparam int unsigned SLOTS = 4;
    localparam int unsigned HOLD_CYCLES = 80;             // long receiver hold-off
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;           // undefined operation
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;     // undefined register index

    // One input word, fields as the block sees them.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] now_ms;
        logic              pin;
        logic [ADC_W-1:0]  adc;
        logic [SLOT_W-1:0] slot;
    } sup_word_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    command_timeout_supervisor_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the supervisor: settings and state.
    logic [TIME_W-1:0] tmo_limit;
    logic [CUR_W-1:0]  brake_ma;
    logic [MODE_W-1:0] kill_sel;
    logic [ADC_W-1:0]  adc_trip;
    logic [FEED_W-1:0] feed_floor;
    logic [MASK_W-1:0] watch_mask;
    logic [TIME_W-1:0] cmd_stamp_ms;
    logic              tmo_flag;
    logic              kill_latch;
    logic [FEED_W-1:0] feed_tally [SLOTS];

    sup_word_t outbound_words [$];      // words waiting for the driver
    result_t   pending_verdicts [$];    // predicted result words, oldest first
    sup_word_t cur_word;
    sup_word_t seen_word;
    result_t   got;
    result_t   want;

    logic word_taken = 1'b0;    // input handshake at the last rising edge
    int   src_gap = 0;
    int   hold_left = 0;
    int   hold_asked = 0;
    int   hold_served = 0;
    bit   src_idle_en = 1'b0;
    bit   sink_idle_en = 1'b0;

    // Values the stimulus steers toward.
    logic [ADC_W-1:0]  gen_thr = ADC_THR_RST;
    logic [FEED_W-1:0] gen_minf = MIN_FEEDS_RST;
    logic [TIME_W-1:0] clock_ms = '0;

    int errors = 0;
    int words_in = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int ticks_seen = 0;
    int brake_ticks = 0;
    int kill_ticks = 0;
    int wd_reloads = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then long.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Predict the result word of one accepted input word and advance the shadow state.
    function automatic result_t supervise_word(input sup_word_t w);
        result_t           r;
        logic              trip;
        logic              expired;
        logic              alive;
        logic [TIME_W-1:0] elapsed;
        r = '0;
        if (w.op == OP_TICK) begin
            case (kill_sel)
                KILL_PIN_LOW:  trip = !w.pin;
                KILL_PIN_HIGH: trip = w.pin;
                KILL_ADC_LOW:  trip = w.adc < adc_trip;
                KILL_ADC_HIGH: trip = w.adc > adc_trip;
                default:       trip = 1'b0;    // off, or an undefined mode
            endcase
            elapsed = w.now_ms - cmd_stamp_ms;    // wraps with the ms counter
            expired = (tmo_limit != '0) && (elapsed > tmo_limit);
            if (trip || expired) begin
                r.brake_apply = 1'b1;
                r.release_override = !tmo_flag && !kill_latch;
                if (trip)
                    r.ignore_input = 1'b1;    // timeout flag holds under kill
                else
                    tmo_flag = 1'b1;
            end else begin
                tmo_flag = 1'b0;
            end
            kill_latch = trip;
            alive = 1'b1;
            for (int i = 0; i < SLOTS; i++) begin
                if (watch_mask[i] && feed_tally[i] < feed_floor)
                    alive = 1'b0;
            end
            for (int i = 0; i < SLOTS; i++)
                feed_tally[i] = '0;
            r.watchdog_feed = alive;
            r.brake_current_out = r.brake_apply ? brake_ma : '0;
            ticks_seen++;
            if (r.brake_apply) brake_ticks++;
            if (trip) kill_ticks++;
            if (alive) wd_reloads++;
        end else if (w.op == OP_REFRESH) begin
            cmd_stamp_ms = w.now_ms;
        end else if (w.op == OP_FEED) begin
            if (w.slot < SLOTS && feed_tally[w.slot] != {FEED_W{1'b1}})
                feed_tally[w.slot] = feed_tally[w.slot] + 1'b1;    // saturates
        end
        r.timed_out = tmo_flag;
        r.kill_active = kill_latch;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Monitor: settings, accepted words and results, all sampled at the rising edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            tmo_limit    = TIMEOUT_RST;
            brake_ma     = BRAKE_CUR_RST;
            kill_sel     = KILL_OFF;
            adc_trip     = ADC_THR_RST;
            feed_floor   = MIN_FEEDS_RST;
            watch_mask   = MON_MASK_RST;
            cmd_stamp_ms = '0;
            tmo_flag     = 1'b0;
            kill_latch   = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                feed_tally[i] = '0;
            pending_verdicts.delete();
            word_taken <= 1'b0;
        end else begin
            word_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TIMEOUT:   tmo_limit  = cfg_data[TIME_W-1:0];
                    CFG_BRAKE_CUR: brake_ma   = cfg_data[CUR_W-1:0];
                    CFG_KILL_MODE: kill_sel   = cfg_data[MODE_W-1:0];
                    CFG_ADC_THR:   adc_trip   = cfg_data[ADC_W-1:0];
                    CFG_MIN_FEEDS: feed_floor = cfg_data[FEED_W-1:0];
                    CFG_MON_MASK:  watch_mask = cfg_data[MASK_W-1:0];
                    default: ;    // undefined index: nothing changes
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (pending_verdicts.size() == 0) begin
                    $error("result word 0x%0h with no prediction waiting", m_tdata);
                    errors++;
                end else begin
                    want = pending_verdicts.pop_front();
                    check_field("brake_apply", want.brake_apply, got.brake_apply);
                    check_field("release_override", want.release_override,
                                got.release_override);
                    check_field("ignore_input", want.ignore_input, got.ignore_input);
                    check_field("timed_out", want.timed_out, got.timed_out);
                    check_field("kill_active", want.kill_active, got.kill_active);
                    check_field("watchdog_feed", want.watchdog_feed, got.watchdog_feed);
                    check_field("brake_current_out", want.brake_current_out,
                                got.brake_current_out);
                    results_seen++;
                end
            end
            if (s_tvalid && s_tready) begin
                seen_word.op     = s_tuser;
                seen_word.now_ms = s_tdata[31:0];
                seen_word.pin    = s_tdata[32];
                seen_word.adc    = s_tdata[44:33];
                seen_word.slot   = s_tdata[46:45];
                pending_verdicts.push_back(supervise_word(seen_word));
                words_in++;
            end
        end
    end

    // Driver: presents the next queued word once the previous one is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (src_gap > 0) begin
                s_tvalid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (outbound_words.size() != 0) begin
                cur_word = outbound_words.pop_front();
                s_tuser  <= cur_word.op;
                s_tdata  <= {1'b0, cur_word.slot, cur_word.adc, cur_word.pin, cur_word.now_ms};
                s_tvalid <= 1'b1;
                src_gap  <= src_idle_en ? gap_length() : 0;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_served <= hold_served + 1;
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            hold_left <= gap_length();
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic push_word(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now_ms,
                             input logic pin, input logic [ADC_W-1:0] adc,
                             input logic [SLOT_W-1:0] slot);
        sup_word_t w;
        w.op = op;
        w.now_ms = now_ms;
        w.pin = pin;
        w.adc = adc;
        w.slot = slot;
        outbound_words.push_back(w);
    endtask

    // Unused fields of each kind carry random values.
    task automatic push_tick(input logic [TIME_W-1:0] now_ms, input logic pin,
                             input logic [ADC_W-1:0] adc);
        push_word(OP_TICK, now_ms, pin, adc, SLOT_W'($urandom));
    endtask

    task automatic push_refresh(input logic [TIME_W-1:0] now_ms);
        push_word(OP_REFRESH, now_ms, 1'($urandom), ADC_W'($urandom), SLOT_W'($urandom));
    endtask

    task automatic push_feed(input logic [SLOT_W-1:0] slot);
        push_word(OP_FEED, $urandom, 1'($urandom), ADC_W'($urandom), slot);
    endtask

    task automatic push_noise();
        push_word(OP_W'($urandom), $urandom, 1'($urandom), ADC_W'($urandom),
                  SLOT_W'($urandom));
    endtask

    // Sender pause: everything sent and every result back, then a short settle.
    task automatic wait_drained();
        while (outbound_words.size() != 0 || s_tvalid || pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Write every register; bits above each register's width carry junk.
    task automatic write_settings(input logic [TIME_W-1:0] tmo, input logic [CUR_W-1:0] cur,
                                  input logic [MODE_W-1:0] mode, input logic [ADC_W-1:0] thr,
                                  input logic [FEED_W-1:0] minf,
                                  input logic [MASK_W-1:0] mask);
        write_reg(CFG_TIMEOUT, tmo);
        write_reg(CFG_BRAKE_CUR, ($urandom << CUR_W) | 32'(cur));
        write_reg(CFG_KILL_MODE, ($urandom << MODE_W) | 32'(mode));
        write_reg(CFG_ADC_THR, ($urandom << ADC_W) | 32'(thr));
        write_reg(CFG_MIN_FEEDS, ($urandom << FEED_W) | 32'(minf));
        write_reg(CFG_MON_MASK, ($urandom << MASK_W) | 32'(mask));
        gen_thr = thr;
        gen_minf = minf;
    endtask

    // Mostly well-formed 10 ms periods (refresh, feeds, tick), the rest noise words.
    task automatic run_traffic(input int n);
        int               sent;
        int               reps;
        int               feed_goal;
        logic [ADC_W-1:0] a;
        logic [ADC_W-1:0] jit;
        sent = 0;
        feed_goal = (gen_minf > 16'd4) ? 4 : int'(gen_minf);
        while (sent < n) begin
            if ($urandom_range(0, 4) == 0) begin
                push_noise();
                sent++;
            end else begin
                if ($urandom_range(0, 9) < 6) begin
                    push_refresh(clock_ms + $urandom_range(0, 9));
                    sent++;
                end
                for (int k = 0; k < SLOTS; k++) begin
                    reps = $urandom_range(0, feed_goal + 1);
                    repeat (reps) push_feed(SLOT_W'(k));
                    sent += reps;
                end
                clock_ms += ($urandom_range(0, 39) == 0) ? $urandom : 32'd10;
                case ($urandom_range(0, 3))
                    0, 1: begin
                        jit = ADC_W'($urandom_range(0, 2));
                        a = gen_thr + jit - 12'd1;    // straddle the threshold
                    end
                    2: a = ADC_W'($urandom);
                    default: a = $urandom_range(0, 1) ? {ADC_W{1'b1}} : '0;
                endcase
                push_tick(clock_ms, 1'($urandom), a);
                sent++;
            end
        end
    endtask

    initial begin
        logic [TIME_W-1:0] tmo;
        logic [CUR_W-1:0]  cur;
        logic [ADC_W-1:0]  thr;
        logic [FEED_W-1:0] minf;
        logic [MASK_W-1:0] mask;
        logic [MODE_W-1:0] mode;
        int                spin;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;

        // Directed, reset settings: feed rule, wrapping elapsed time, timeout boundary.
        push_tick(32'd0, 1'b0, '0);                 // no feeds yet: no reload
        push_feed(2'd0);
        push_tick(32'd10, 1'b1, {ADC_W{1'b1}});     // slot 0 fed: reload
        push_feed(2'd1);
        push_feed(2'd2);
        push_feed(2'd3);
        push_feed(2'd3);
        push_tick(32'd20, 1'b0, '0);                // monitored slot 0 starved
        push_word(OP_SPARE, $urandom, 1'($urandom), ADC_W'($urandom), SLOT_W'($urandom));
        push_refresh(32'hFFFF_FFF0);
        push_tick(32'h0000_0010, 1'b1, '0);          // elapsed wraps to 0x20
        push_tick(32'hFFFF_FFF0 + 32'd1001, 1'b0, '0);    // just past timeout
        push_tick(32'hFFFF_FFF0 + 32'd1011, 1'b0, '0);    // still timed out
        push_tick(32'hFFFF_FFF0 + 32'd1000, 1'b0, '0);    // exactly at limit
        push_tick(32'hFFFF_FFFF, 1'b1, {ADC_W{1'b1}});
        wait_drained();

        // Extremes: timeout off, full brake current, pin-low kill, all slots watched.
        write_settings('0, {CUR_W{1'b1}}, KILL_PIN_LOW, '0, {FEED_W{1'b1}}, {MASK_W{1'b1}});
        write_reg(CFG_SPARE, $urandom);
        push_tick(32'd5, 1'b0, '0);                 // kill opens an episode
        push_tick(32'd15, 1'b0, {ADC_W{1'b1}});     // kill held
        push_tick(32'd25, 1'b1, '0);                // released
        push_tick(32'hFFFF_FFFF, 1'b1, '0);         // timeout disabled
        push_refresh(32'hFFFF_FFFF);
        push_tick(32'h7FFF_FFFF, 1'b0, '0);
        wait_drained();

        // Feed threshold, back to back: one feed short fails, exact count reloads.
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        write_settings(TIMEOUT_RST, CUR_W'($urandom), KILL_OFF, ADC_W'($urandom), 16'd20, 4'h3);
        repeat (20) push_feed(2'd0);
        repeat (19) push_feed(2'd1);
        push_feed(2'd2);
        push_tick(32'd0, 1'b0, '0);                 // slot 1 one short: no reload
        repeat (20) push_feed(2'd0);
        repeat (20) push_feed(2'd1);
        push_tick(32'd10, 1'b0, '0);                // both at the floor: reload
        push_tick(32'd20, 1'b0, '0);                // counters cleared: no reload
        wait_drained();

        // Random phases over a spread of settings.
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: tmo = '0;
                1: tmo = $urandom_range(1, 60);
                2: tmo = {TIME_W{1'b1}};
                default: tmo = $urandom_range(15, 45);
            endcase
            cur = (p == 1) ? {CUR_W{1'b1}} : (p == 2) ? '0 : CUR_W'($urandom);
            mode = MODE_W'(p);    // walks every mode, the undefined ones too
            thr = (p == 3) ? '0 : (p == 4) ? {ADC_W{1'b1}} : ADC_W'($urandom);
            case (p % 3)
                0: minf = '0;
                1: minf = FEED_W'($urandom_range(1, 3));
                default: minf = 16'd1;
            endcase
            mask = (p == 0) ? {MASK_W{1'b1}} : (p == 1) ? '0 : MASK_W'($urandom);
            write_settings(tmo, cur, mode, thr, minf, mask);
            clock_ms = $urandom;
            src_idle_en = (p % 3 != 0);
            sink_idle_en = (p % 4 != 1);
            if (p == 2) begin
                src_idle_en = 1'b0;    // keep offering words through the hold-off
                hold_asked++;
            end
            run_traffic(85);
            wait_drained();
            run_traffic(85);
            wait_drained();
        end

        // Final drain, bounded.
        while (outbound_words.size() != 0 || s_tvalid) @(posedge aclk);
        spin = 0;
        while (pending_verdicts.size() != 0 && spin < 500) begin
            @(posedge aclk);
            spin++;
        end
        repeat (5) @(posedge aclk);
        if (pending_verdicts.size() != 0) begin
            $error("%0d predicted results never arrived", pending_verdicts.size());
            errors++;
        end

        $display("summary: %0d words in, %0d results checked, %0d register writes",
                 words_in, results_seen, cfg_writes);
        $display("summary: %0d ticks, %0d braked, %0d killed, %0d watchdog reloads",
                 ticks_seen, brake_ticks, kill_ticks, wd_reloads);
        if (errors == 0)
            $display("command_timeout_supervisor_top_test: done, clean");
        else
            $display("command_timeout_supervisor_top_test: done, errors");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #20000000;
        $display("command_timeout_supervisor_top_test: done, errors");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/cts_pkg.sv
rtl/command_timeout_supervisor_top.sv
bench/command_timeout_supervisor_top_test.sv
